@@ src/gmd_pkg.sv @@
// Shared types and constants for the grid maze depth-first search solver.
package gmd_pkg;

  localparam int unsigned DIM_W   = 6;   // row / column coordinate width
  localparam int unsigned CNT_W   = 11;  // coin count and path length width
  localparam int unsigned PIDX_W  = 10;  // path index width
  localparam int unsigned CFG_IW  = 3;   // config register index width

  typedef enum logic [1:0] {
    REQ_PLACE = 2'd0,
    REQ_SOLVE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_HIT     = 2'd1,
    STATUS_OUTSIDE = 2'd2,
    STATUS_BEYOND  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_OPEN = 2'd0,
    KIND_WALL = 2'd1,
    KIND_COIN = 2'd2
  } kind_e;

  typedef enum logic [CFG_IW-1:0] {
    CFG_ROWS      = 3'd0,
    CFG_COLS      = 3'd1,
    CFG_START_ROW = 3'd2,
    CFG_START_COL = 3'd3,
    CFG_END_ROW   = 3'd4,
    CFG_END_COL   = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_INIT_CLR,
    S_IDLE,
    S_SEEN_CLR,
    S_SOLVE_BEGIN,
    S_CHECK,
    S_NBR,
    S_EVAL,
    S_POP,
    S_POP_LD,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [DIM_W-1:0]  cell_row;
    logic [DIM_W-1:0]  cell_col;
    logic              cell_kind;
    logic [PIDX_W-1:0] path_index;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             solved;
    logic [CNT_W-1:0] coin_count;
    logic [CNT_W-1:0] path_length;
    logic [DIM_W-1:0] path_row;
    logic [DIM_W-1:0] path_col;
  } res_t;

  typedef struct packed {
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
  } coord_t;

  typedef struct packed {
    coord_t pos;
    logic   in_grid;
  } nbr_t;

  typedef struct packed {
    logic       kind_we;
    logic [1:0] kind_wdata;
    logic       seen_we;
    logic       seen_wdata;
  } cell_ctl_t;

endpackage

@@ src/gmd_addr_unit.sv @@
// Shared coordinate unit: neighbor step, grid bounds check and cell address.
module gmd_addr_unit #(
  parameter int unsigned MAX_COLS = 32,
  parameter int unsigned CELL_AW  = 10
) (
  input  gmd_pkg::coord_t               base_i,
  input  logic [1:0]                    dir_i,
  input  logic                          use_dir_i,
  input  logic [gmd_pkg::DIM_W-1:0]     rows_i,
  input  logic [gmd_pkg::DIM_W-1:0]     cols_i,
  output gmd_pkg::nbr_t                 nbr_o,
  output logic [CELL_AW-1:0]            addr_o
);

  logic [gmd_pkg::DIM_W:0] r7, c7, rm1, cm1;

  // step one cell in the chosen direction: row+1, col+1, row-1, col-1
  always_comb begin
    r7 = {1'b0, base_i.row};
    c7 = {1'b0, base_i.col};
    if (use_dir_i) begin
      case (dir_i)
        2'd0:    r7 = r7 + 1'b1;
        2'd1:    c7 = c7 + 1'b1;
        2'd2:    r7 = r7 - 1'b1;
        default: c7 = c7 - 1'b1;
      endcase
    end
    rm1 = r7 - 1'b1;
    cm1 = c7 - 1'b1;
  end

  assign nbr_o.pos.row = r7[gmd_pkg::DIM_W-1:0];
  assign nbr_o.pos.col = c7[gmd_pkg::DIM_W-1:0];
  assign nbr_o.in_grid = (r7 != '0) && (r7 <= {1'b0, rows_i}) &&
                         (c7 != '0) && (c7 <= {1'b0, cols_i});

  // row-major cell address
  assign addr_o = CELL_AW'(rm1) * CELL_AW'(MAX_COLS) + CELL_AW'(cm1);

endmodule

@@ src/gmd_cell_mem.sv @@
// Cell kind memory and per-solve visited memory.
module gmd_cell_mem #(
  parameter int unsigned NCELLS  = 1024,
  parameter int unsigned CELL_AW = 10
) (
  input  logic                 clk_i,
  input  gmd_pkg::cell_ctl_t   ctl_i,
  input  logic [CELL_AW-1:0]   kind_addr_i,
  input  logic [CELL_AW-1:0]   seen_addr_i,
  output logic [1:0]           kind_o,
  output logic                 seen_o
);

  logic [1:0] kind_mem [NCELLS];
  logic       seen_mem [NCELLS];

  // kind store: one registered read per cycle, plus a write when kind_we is set
  always_ff @(posedge clk_i) begin
    if (ctl_i.kind_we) begin
      kind_mem[kind_addr_i] <= ctl_i.kind_wdata;
    end
    kind_o <= kind_mem[kind_addr_i];
  end

  // visited bits
  always_ff @(posedge clk_i) begin
    if (ctl_i.seen_we) begin
      seen_mem[seen_addr_i] <= ctl_i.seen_wdata;
    end
    seen_o <= seen_mem[seen_addr_i];
  end

endmodule

@@ src/gmd_stack_mem.sv @@
// Path stack memory holding row/column entries.
module gmd_stack_mem #(
  parameter int unsigned STK_DEPTH = 1025,
  parameter int unsigned STK_AW    = 11
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [STK_AW-1:0]   addr_i,
  input  gmd_pkg::coord_t     wdata_i,
  output gmd_pkg::coord_t     rdata_o
);

  gmd_pkg::coord_t mem [STK_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

@@ src/grid_maze_depth_first_search.sv @@
// Top level: grid maze depth-first search solver with sequencer and registers.
//
//  channel  | signals                               | transfer when
//  ---------+---------------------------------------+----------------------------
//  request  | start, busy, req_i                    | start high and busy low
//  result   | res_valid_o, res_o                    | res_valid_o high (one cycle)
//  config   | cfg_valid_i, cfg_ready_o, cfg_index_i,| cfg_valid_i and cfg_ready_o
//           | cfg_data_i                            |
//
// Place and read go straight to the response state; clear first sweeps every
// cell open. A solve sweeps the visited memory, pushes the start, then checks
// the top, probes each neighbor (a neighbor inside the grid also takes an
// evaluation state) and pops (each pop but the last loads the entry below),
// as the single-ported cell and stack memories require. After reset the cell
// memory is swept with busy high. The result strobe cannot be stalled.
module grid_maze_depth_first_search #(
  parameter int unsigned MAX_ROWS = 32,
  parameter int unsigned MAX_COLS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  gmd_pkg::req_t                     req_i,
  output logic                              res_valid_o,
  output gmd_pkg::res_t                     res_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gmd_pkg::CFG_IW-1:0]        cfg_index_i,
  input  logic [gmd_pkg::DIM_W-1:0]         cfg_data_i
);

  localparam int unsigned NCELLS    = MAX_ROWS * MAX_COLS;
  localparam int unsigned CELL_AW   = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int unsigned STK_DEPTH = NCELLS + 1;
  localparam int unsigned STK_AW    = $clog2(STK_DEPTH);
  localparam int unsigned SP_W      = $clog2(STK_DEPTH + 1);
  localparam int unsigned CMP_W     = (SP_W > gmd_pkg::PIDX_W) ? SP_W : gmd_pkg::PIDX_W;
  localparam int unsigned DW        = gmd_pkg::DIM_W;

  gmd_pkg::state_e    state_q, state_d;
  gmd_pkg::req_e      req_q, req_d;
  gmd_pkg::status_e   status_q, status_d;
  logic [1:0]         dir_q, dir_d;
  logic [CELL_AW-1:0] sweep_q, sweep_d;
  gmd_pkg::coord_t    top_q, top_d, nbr_q, nbr_d;
  logic [CELL_AW-1:0] nbr_addr_q, nbr_addr_d;
  logic [SP_W-1:0]    depth_q, depth_d, pop_addr;
  logic               found_q, found_d, clr_item_q, clr_item_d;
  logic [gmd_pkg::CNT_W-1:0] coins_q, coins_d;
  logic               res_valid_q, res_valid_d;
  gmd_pkg::res_t      res_q, res_d;

  logic [DW-1:0] rows_q, cols_q, srow_q, scol_q, erow_q, ecol_q;
  logic [DW-1:0] rows_lim, cols_lim;

  gmd_pkg::coord_t    u_base, start_pos, end_pos, stk_wdata, stk_rd;
  logic               u_use_dir;
  gmd_pkg::nbr_t      u_nbr;
  logic [CELL_AW-1:0] u_addr, kind_addr, seen_addr;
  gmd_pkg::cell_ctl_t cell_ctl;
  logic [1:0]         kind_rd;
  logic               seen_rd, stk_we;
  logic [STK_AW-1:0]  stk_addr;
  gmd_pkg::kind_e     eval_kind;

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q != gmd_pkg::S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign start_pos   = '{row: srow_q, col: scol_q};
  assign end_pos     = '{row: erow_q, col: ecol_q};
  assign pop_addr    = depth_q - SP_W'(2);

  // grid size clamped to 1..MAX
  always_comb begin
    rows_lim = rows_q;
    cols_lim = cols_q;
    if (rows_q == '0) begin
      rows_lim = DW'(1);
    end else if (int'(rows_q) > MAX_ROWS) begin
      rows_lim = DW'(MAX_ROWS);
    end
    if (cols_q == '0) begin
      cols_lim = DW'(1);
    end else if (int'(cols_q) > MAX_COLS) begin
      cols_lim = DW'(MAX_COLS);
    end
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DW'(1);
      cols_q <= DW'(1);
      srow_q <= DW'(1);
      scol_q <= DW'(1);
      erow_q <= DW'(1);
      ecol_q <= DW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (gmd_pkg::cfg_idx_e'(cfg_index_i))
        gmd_pkg::CFG_ROWS:      rows_q <= cfg_data_i;
        gmd_pkg::CFG_COLS:      cols_q <= cfg_data_i;
        gmd_pkg::CFG_START_ROW: srow_q <= cfg_data_i;
        gmd_pkg::CFG_START_COL: scol_q <= cfg_data_i;
        gmd_pkg::CFG_END_ROW:   erow_q <= cfg_data_i;
        gmd_pkg::CFG_END_COL:   ecol_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // shared coordinate unit input select
  always_comb begin
    u_base    = top_q;
    u_use_dir = 1'b1;
    if (state_q == gmd_pkg::S_IDLE) begin
      u_base    = '{row: req_i.cell_row, col: req_i.cell_col};
      u_use_dir = 1'b0;
    end else if (state_q == gmd_pkg::S_SOLVE_BEGIN) begin
      u_base    = start_pos;
      u_use_dir = 1'b0;
    end
  end

  gmd_addr_unit #(
    .MAX_COLS (MAX_COLS),
    .CELL_AW  (CELL_AW)
  ) u_addr_unit (
    .base_i    (u_base),
    .dir_i     (dir_q),
    .use_dir_i (u_use_dir),
    .rows_i    (rows_lim),
    .cols_i    (cols_lim),
    .nbr_o     (u_nbr),
    .addr_o    (u_addr)
  );

  gmd_cell_mem #(
    .NCELLS  (NCELLS),
    .CELL_AW (CELL_AW)
  ) u_cell_mem (
    .clk_i       (clk_i),
    .ctl_i       (cell_ctl),
    .kind_addr_i (kind_addr),
    .seen_addr_i (seen_addr),
    .kind_o      (kind_rd),
    .seen_o      (seen_rd)
  );

  gmd_stack_mem #(
    .STK_DEPTH (STK_DEPTH),
    .STK_AW    (STK_AW)
  ) u_stack_mem (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .addr_i  (stk_addr),
    .wdata_i (stk_wdata),
    .rdata_o (stk_rd)
  );

  // start and end always count as open
  always_comb begin
    eval_kind = gmd_pkg::kind_e'(kind_rd);
    if (nbr_q == start_pos || nbr_q == end_pos) begin
      eval_kind = gmd_pkg::KIND_OPEN;
    end
  end

  // sequencer: next state and memory controls
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    status_d    = status_q;
    dir_d       = dir_q;
    sweep_d     = sweep_q;
    top_d       = top_q;
    nbr_d       = nbr_q;
    nbr_addr_d  = nbr_addr_q;
    depth_d     = depth_q;
    found_d     = found_q;
    coins_d     = coins_q;
    clr_item_d  = clr_item_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    cell_ctl    = '0;
    kind_addr   = u_addr;
    seen_addr   = u_addr;
    stk_we      = 1'b0;
    stk_addr    = depth_q[STK_AW-1:0];
    stk_wdata   = nbr_q;

    unique case (state_q)
      // open every cell, after reset and on clear
      gmd_pkg::S_INIT_CLR: begin
        cell_ctl.kind_we    = 1'b1;
        cell_ctl.kind_wdata = gmd_pkg::KIND_OPEN;
        kind_addr           = sweep_q;
        if (sweep_q == CELL_AW'(NCELLS - 1)) begin
          sweep_d    = '0;
          clr_item_d = 1'b0;
          state_d    = clr_item_q ? gmd_pkg::S_RESP : gmd_pkg::S_IDLE;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end

      gmd_pkg::S_IDLE: begin
        if (start) begin
          req_d    = gmd_pkg::req_e'(req_i.req_type);
          status_d = gmd_pkg::STATUS_OK;
          state_d  = gmd_pkg::S_RESP;
          unique case (gmd_pkg::req_e'(req_i.req_type))
            gmd_pkg::REQ_PLACE: begin
              if (u_nbr.pos == start_pos || u_nbr.pos == end_pos) begin
                status_d = gmd_pkg::STATUS_HIT;
              end else if (!u_nbr.in_grid) begin
                status_d = gmd_pkg::STATUS_OUTSIDE;
              end else begin
                cell_ctl.kind_we    = 1'b1;
                cell_ctl.kind_wdata = req_i.cell_kind ? gmd_pkg::KIND_COIN
                                                      : gmd_pkg::KIND_WALL;
              end
            end
            gmd_pkg::REQ_SOLVE: begin
              depth_d = '0;
              found_d = 1'b0;
              coins_d = '0;
              sweep_d = '0;
              state_d = gmd_pkg::S_SEEN_CLR;
            end
            gmd_pkg::REQ_READ: begin
              if (CMP_W'(req_i.path_index) < CMP_W'(depth_q)) begin
                stk_addr = STK_AW'(req_i.path_index);
              end else begin
                status_d = gmd_pkg::STATUS_BEYOND;
              end
            end
            default: begin
              depth_d    = '0;
              found_d    = 1'b0;
              coins_d    = '0;
              sweep_d    = '0;
              clr_item_d = 1'b1;
              state_d    = gmd_pkg::S_INIT_CLR;
            end
          endcase
        end
      end

      // wipe visited bits before the search
      gmd_pkg::S_SEEN_CLR: begin
        cell_ctl.seen_we    = 1'b1;
        cell_ctl.seen_wdata = 1'b0;
        seen_addr           = sweep_q;
        if (sweep_q == CELL_AW'(NCELLS - 1)) begin
          sweep_d = '0;
          state_d = gmd_pkg::S_SOLVE_BEGIN;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end

      // push start cell unless it lies off the grid
      gmd_pkg::S_SOLVE_BEGIN: begin
        if (u_nbr.in_grid) begin
          stk_we    = 1'b1;
          stk_addr  = '0;
          stk_wdata = start_pos;
          top_d     = start_pos;
          depth_d   = SP_W'(1);
          state_d   = gmd_pkg::S_CHECK;
        end else begin
          state_d = gmd_pkg::S_RESP;
        end
      end

      gmd_pkg::S_CHECK: begin
        if (top_q == end_pos) begin
          found_d = 1'b1;
          state_d = gmd_pkg::S_RESP;
        end else begin
          dir_d   = '0;
          state_d = gmd_pkg::S_NBR;
        end
      end

      // probe neighbor; memory reads issue at the unit's address
      gmd_pkg::S_NBR: begin
        if (!u_nbr.in_grid) begin
          if (dir_q == 2'd3) begin
            state_d = gmd_pkg::S_POP;
          end else begin
            dir_d = dir_q + 1'b1;
          end
        end else begin
          nbr_d      = u_nbr.pos;
          nbr_addr_d = u_addr;
          state_d    = gmd_pkg::S_EVAL;
        end
      end

      gmd_pkg::S_EVAL: begin
        if (seen_rd || eval_kind == gmd_pkg::KIND_WALL) begin
          if (dir_q == 2'd3) begin
            state_d = gmd_pkg::S_POP;
          end else begin
            dir_d   = dir_q + 1'b1;
            state_d = gmd_pkg::S_NBR;
          end
        end else begin
          if (eval_kind == gmd_pkg::KIND_COIN) begin
            coins_d = coins_q + 1'b1;
          end
          cell_ctl.seen_we    = 1'b1;
          cell_ctl.seen_wdata = 1'b1;
          seen_addr           = nbr_addr_q;
          if (int'(depth_q) < STK_DEPTH) begin
            stk_we  = 1'b1;
            depth_d = depth_q + 1'b1;
            top_d   = nbr_q;
          end
          state_d = gmd_pkg::S_CHECK;
        end
      end

      // drop top; fetch the entry below it
      gmd_pkg::S_POP: begin
        depth_d = depth_q - 1'b1;
        if (depth_q == SP_W'(1)) begin
          state_d = gmd_pkg::S_RESP;
        end else begin
          stk_addr = pop_addr[STK_AW-1:0];
          state_d  = gmd_pkg::S_POP_LD;
        end
      end

      gmd_pkg::S_POP_LD: begin
        top_d   = stk_rd;
        state_d = gmd_pkg::S_CHECK;
      end

      gmd_pkg::S_RESP: begin
        res_valid_d       = 1'b1;
        res_d.status      = status_q;
        res_d.solved      = found_q;
        res_d.coin_count  = coins_q;
        res_d.path_length = gmd_pkg::CNT_W'(depth_q);
        res_d.path_row    = '0;
        res_d.path_col    = '0;
        if (req_q == gmd_pkg::REQ_READ && status_q == gmd_pkg::STATUS_OK) begin
          res_d.path_row = stk_rd.row;
          res_d.path_col = stk_rd.col;
        end
        state_d = gmd_pkg::S_IDLE;
      end

      default: state_d = gmd_pkg::S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gmd_pkg::S_INIT_CLR;
      req_q       <= gmd_pkg::REQ_PLACE;
      status_q    <= gmd_pkg::STATUS_OK;
      dir_q       <= '0;
      sweep_q     <= '0;
      depth_q     <= '0;
      found_q     <= 1'b0;
      coins_q     <= '0;
      clr_item_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      req_q       <= req_d;
      status_q    <= status_d;
      dir_q       <= dir_d;
      sweep_q     <= sweep_d;
      depth_q     <= depth_d;
      found_q     <= found_d;
      coins_q     <= coins_d;
      clr_item_q  <= clr_item_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    top_q      <= top_d;
    nbr_q      <= nbr_d;
    nbr_addr_q <= nbr_addr_d;
    res_q      <= res_d;
  end

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench for the grid maze depth-first search solver with driver, monitor and predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int GRID  = 32;
  localparam int NCELL = GRID * GRID;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       start       = 1'b0;
  logic                       busy;
  gmd_pkg::req_t              req_i       = '0;
  logic                       res_valid_o;
  gmd_pkg::res_t              res_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [gmd_pkg::CFG_IW-1:0] cfg_index_i = gmd_pkg::CFG_ROWS;
  logic [gmd_pkg::DIM_W-1:0]  cfg_data_i  = '0;

  grid_maze_depth_first_search dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Predictor state: register mirror, maze cells, search stack
  logic [gmd_pkg::DIM_W-1:0] cfg_mirror [0:5] = '{default: 6'd1};
  gmd_pkg::kind_e   maze_cell  [NCELL] = '{default: gmd_pkg::KIND_OPEN};
  logic             visited    [NCELL];
  logic [9:0]       walk_stack [NCELL+1];
  int               walk_depth = 0;
  logic             goal_found = 1'b0;
  int               coins_taken = 0;

  gmd_pkg::req_t item_q   [$];
  gmd_pkg::res_t result_q [$];
  gmd_pkg::res_t head_res;
  int   errors     = 0;
  int   accepted_n = 0;
  int   queued_n   = 0;

  function automatic int clamp_dim(int v);
    return (v < 1) ? 1 : ((v > GRID) ? GRID : v);
  endfunction

  // Compute the result of one request and update the maze state
  function automatic gmd_pkg::res_t maze_apply(gmd_pkg::req_t r);
    gmd_pkg::res_t  o;
    int    rows, cols, sr, sc, er, ec, tr, tc, nr, nc, d, idx;
    bit    moved;
    gmd_pkg::kind_e k;
    int    drow [4] = '{1, 0, -1, 0};
    int    dcol [4] = '{0, 1, 0, -1};
    o    = '0;
    rows = clamp_dim(cfg_mirror[gmd_pkg::CFG_ROWS]);
    cols = clamp_dim(cfg_mirror[gmd_pkg::CFG_COLS]);
    sr   = cfg_mirror[gmd_pkg::CFG_START_ROW];
    sc   = cfg_mirror[gmd_pkg::CFG_START_COL];
    er   = cfg_mirror[gmd_pkg::CFG_END_ROW];
    ec   = cfg_mirror[gmd_pkg::CFG_END_COL];
    case (gmd_pkg::req_e'(r.req_type))
      gmd_pkg::REQ_PLACE: begin
        if ((r.cell_row == sr && r.cell_col == sc) || (r.cell_row == er && r.cell_col == ec))
          o.status = gmd_pkg::STATUS_HIT;
        else if (r.cell_row < 1 || r.cell_row > rows || r.cell_col < 1 || r.cell_col > cols)
          o.status = gmd_pkg::STATUS_OUTSIDE;
        else
          maze_cell[(int'(r.cell_row) - 1) * GRID + int'(r.cell_col) - 1] =
            r.cell_kind ? gmd_pkg::KIND_COIN : gmd_pkg::KIND_WALL;
      end
      gmd_pkg::REQ_SOLVE: begin
        foreach (visited[i]) visited[i] = 1'b0;
        walk_depth  = 0;
        goal_found  = 1'b0;
        coins_taken = 0;
        if (sr >= 1 && sr <= rows && sc >= 1 && sc <= cols) begin
          walk_stack[0] = 10'((sr - 1) * GRID + sc - 1);
          walk_depth    = 1;
        end
        // Walk until the goal is on top or the stack runs dry
        while (walk_depth > 0) begin
          tr = walk_stack[walk_depth-1] / GRID + 1;
          tc = walk_stack[walk_depth-1] % GRID + 1;
          if (tr == er && tc == ec) begin
            goal_found = 1'b1;
            break;
          end
          moved = 1'b0;
          for (d = 0; d < 4 && !moved; d++) begin
            nr = tr + drow[d];
            nc = tc + dcol[d];
            if (nr >= 1 && nr <= rows && nc >= 1 && nc <= cols) begin
              idx = (nr - 1) * GRID + nc - 1;
              k   = maze_cell[idx];
              // start and end always count as open
              if ((nr == sr && nc == sc) || (nr == er && nc == ec)) k = gmd_pkg::KIND_OPEN;
              if (!visited[idx] && k != gmd_pkg::KIND_WALL) begin
                if (k == gmd_pkg::KIND_COIN) coins_taken++;
                visited[idx] = 1'b1;
                if (walk_depth < NCELL + 1) begin
                  walk_stack[walk_depth] = 10'(idx);
                  walk_depth++;
                end
                moved = 1'b1;
              end
            end
          end
          if (!moved) walk_depth--;
        end
      end
      gmd_pkg::REQ_READ: begin
        if (r.path_index < walk_depth) begin
          o.path_row = gmd_pkg::DIM_W'(walk_stack[r.path_index] / GRID + 1);
          o.path_col = gmd_pkg::DIM_W'(walk_stack[r.path_index] % GRID + 1);
        end else begin
          o.status = gmd_pkg::STATUS_BEYOND;
        end
      end
      default: begin
        foreach (maze_cell[i]) maze_cell[i] = gmd_pkg::KIND_OPEN;
        walk_depth  = 0;
        goal_found  = 1'b0;
        coins_taken = 0;
      end
    endcase
    o.solved      = goal_found;
    o.coin_count  = gmd_pkg::CNT_W'(coins_taken);
    o.path_length = gmd_pkg::CNT_W'(walk_depth);
    return o;
  endfunction

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Sender gaps: none while accepted items 300..449 go through
  function automatic bit take_gap();
    if (accepted_n >= 300 && accepted_n < 450) return 1'b0;
    return $urandom_range(99) < 31;
  endfunction

  // Request driver: predicts each transfer, then presents the next item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      req_i <= '0;
    end else begin
      if (start && !busy) begin
        result_q.push_back(maze_apply(req_i));
        accepted_n++;
      end
      if (!start || !busy) begin
        if (item_q.size() > 0 && !take_gap()) begin
          start <= 1'b1;
          req_i <= item_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, res_o);
        errors++;
      end else begin
        head_res = result_q.pop_front();
        if (res_o.status !== head_res.status || res_o.solved !== head_res.solved ||
            res_o.coin_count !== head_res.coin_count ||
            res_o.path_length !== head_res.path_length ||
            res_o.path_row !== head_res.path_row || res_o.path_col !== head_res.path_col) begin
          $display("%0t: result mismatch, expected %p, actual %p", $time, head_res, res_o);
          errors++;
        end
      end
    end
  end

  // Register write on the config channel; mirror updated on the transfer
  task automatic write_reg(gmd_pkg::cfg_idx_e idx, int value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= gmd_pkg::DIM_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_mirror[idx] = gmd_pkg::DIM_W'(value);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_maze(int rows, int cols, int sr, int sc, int er, int ec);
    write_reg(gmd_pkg::CFG_ROWS, rows);
    write_reg(gmd_pkg::CFG_COLS, cols);
    write_reg(gmd_pkg::CFG_START_ROW, sr);
    write_reg(gmd_pkg::CFG_START_COL, sc);
    write_reg(gmd_pkg::CFG_END_ROW, er);
    write_reg(gmd_pkg::CFG_END_COL, ec);
  endtask

  task automatic push_req(gmd_pkg::req_e kind, int row, int col, bit coin, int pidx);
    gmd_pkg::req_t r;
    r.req_type   = kind;
    r.cell_row   = gmd_pkg::DIM_W'(row);
    r.cell_col   = gmd_pkg::DIM_W'(col);
    r.cell_kind  = coin;
    r.path_index = gmd_pkg::PIDX_W'(pidx);
    item_q.push_back(r);
    queued_n++;
  endtask

  // Let every queued item and its result go through, then settle
  task automatic drain();
    while (item_q.size() > 0 || start || result_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic int pick_dim();
    int p;
    p = $urandom_range(99);
    if (p < 70) return $urandom_range(1, 8);
    if (p < 88) return $urandom_range(1, 32);
    if (p < 94) return 32;
    return $urandom_range(0, 63);
  endfunction

  function automatic int pick_in(int lim);
    if ($urandom_range(99) < 88) return $urandom_range(1, clamp_dim(lim));
    return $urandom_range(0, 63);
  endfunction

  // Stimulus
  initial begin
    int rows, cols, places, reads;
    gmd_pkg::req_t noise;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: rejects, overwrite, solve, reads, clear
    set_maze(4, 5, 1, 1, 4, 5);
    push_req(gmd_pkg::REQ_PLACE, 1, 1, 0, 0);
    push_req(gmd_pkg::REQ_PLACE, 4, 5, 1, 0);
    push_req(gmd_pkg::REQ_PLACE, 0, 3, 0, 0);
    push_req(gmd_pkg::REQ_PLACE, 5, 1, 0, 0);
    push_req(gmd_pkg::REQ_PLACE, 2, 6, 1, 0);
    push_req(gmd_pkg::REQ_PLACE, 63, 63, 1, 0);
    push_req(gmd_pkg::REQ_PLACE, 2, 1, 0, 0);
    push_req(gmd_pkg::REQ_PLACE, 2, 1, 1, 0);
    push_req(gmd_pkg::REQ_PLACE, 1, 2, 1, 0);
    push_req(gmd_pkg::REQ_PLACE, 3, 1, 0, 0);
    push_req(gmd_pkg::REQ_PLACE, 4, 4, 0, 0);
    push_req(gmd_pkg::REQ_SOLVE, 0, 0, 0, 0);
    push_req(gmd_pkg::REQ_READ, 0, 0, 0, 0);
    push_req(gmd_pkg::REQ_READ, 0, 0, 0, 1);
    push_req(gmd_pkg::REQ_READ, 0, 0, 0, 1023);
    push_req(gmd_pkg::REQ_SOLVE, 0, 0, 0, 0);
    push_req(gmd_pkg::REQ_CLEAR, 0, 0, 0, 0);
    push_req(gmd_pkg::REQ_READ, 0, 0, 0, 0);
    drain();
    // start outside the grid with clamped size, then end outside
    set_maze(0, 63, 63, 1, 1, 40);
    push_req(gmd_pkg::REQ_SOLVE, 0, 0, 0, 0);
    drain();
    set_maze(3, 3, 2, 2, 63, 63);
    push_req(gmd_pkg::REQ_SOLVE, 0, 0, 0, 0);
    push_req(gmd_pkg::REQ_READ, 0, 0, 0, 0);
    drain();
    set_maze(32, 32, 1, 1, 32, 32);
    push_req(gmd_pkg::REQ_SOLVE, 0, 0, 0, 0);
    push_req(gmd_pkg::REQ_READ, 0, 0, 0, 62);
    drain();

    // Random phases of place / solve / read sequences
    while (queued_n < 800) begin
      rows = pick_dim();
      cols = pick_dim();
      set_maze(rows, cols, pick_in(rows), pick_in(cols), pick_in(rows), pick_in(cols));
      repeat (3) begin
        if ($urandom_range(3) == 0) push_req(gmd_pkg::REQ_CLEAR, 0, 0, 0, 0);
        places = $urandom_range(0, (clamp_dim(rows) * clamp_dim(cols)) / 3 + 2);
        if (places > 25) places = 25;
        repeat (places)
          push_req(gmd_pkg::REQ_PLACE, pick_in(rows), pick_in(cols), $urandom_range(1), 0);
        push_req(gmd_pkg::REQ_SOLVE, 0, 0, 0, 0);
        reads = $urandom_range(2, 6);
        repeat (reads) begin
          if ($urandom_range(99) < 70)
            push_req(gmd_pkg::REQ_READ, 0, 0, 0,
                     $urandom_range(0, clamp_dim(rows) + clamp_dim(cols)));
          else
            push_req(gmd_pkg::REQ_READ, 0, 0, 0, $urandom_range(0, 1023));
        end
        if ($urandom_range(99) < 20) begin
          noise = gmd_pkg::req_t'($urandom);
          if (noise.req_type == gmd_pkg::REQ_CLEAR && $urandom_range(1))
            noise.req_type = gmd_pkg::REQ_READ;
          item_q.push_back(noise);
          queued_n++;
        end
      end
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Watchdog
  initial begin
    #(64'd200_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ files.f @@
src/gmd_pkg.sv
src/gmd_addr_unit.sv
src/gmd_cell_mem.sv
src/gmd_stack_mem.sv
src/grid_maze_depth_first_search.sv
tb/sv/tb_top.sv
